// ===== hdl/cmst_pkg.sv =====
// Package for the counted multiset table: sizes, codes, request/response
// structs and the control/link types shared by the top level and its cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmst_pkg;

  localparam int CAPACITY = 64;
  localparam int ELEM_W   = 32;
  localparam int COUNT_W  = 16;

  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W   = $clog2(CAPACITY + 1);
  localparam int TOTAL_W  = 23;

  // Request and response payload widths are fixed by the interface.
  localparam int CMD_W      = 2;
  localparam int ELEMENT_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 16;
  localparam int DISTINCT_W = 7;
  localparam int TOTAL_OUT_W = 22;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_SATURATED = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE   = 1'b0,
    FSM_UPDATE = 1'b1
  } fsm_e;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [ELEMENT_W-1:0] element;
  } in_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic                   present;
    logic [OCC_W-1:0]       occurrences;
    logic [DISTINCT_W-1:0]  distinct_count;
    logic [TOTAL_OUT_W-1:0] total_count;
    logic                   is_empty;
  } out_rsp_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              capture;  // latch match result against key
    logic              update;   // apply the operation this cycle
    logic              add;
    logic              rem;
    logic              append;   // write key into the first free slot
    logic [USED_W-1:0] used;
  } cmst_ctrl_t;

  // Passed left to right along the chain.
  typedef struct packed {
    logic               shift;   // a slot at or left of here is deleted
    logic               found;
    logic [COUNT_W-1:0] cnt;     // count of the matching slot, else zero
  } cmst_link_t;

endpackage

`default_nettype wire

// ===== hdl/cmst_cell.sv =====
// One slot of the counted multiset table: value, count and match flag.
// Depends on cmst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmst_cell import cmst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [IDX_W-1:0]   idx_i,
  input  cmst_ctrl_t         ctrl_i,
  input  logic [ELEM_W-1:0]  key_i,
  input  cmst_link_t         link_i,
  output cmst_link_t         link_o,
  input  logic [ELEM_W-1:0]  nb_val_i,
  input  logic [COUNT_W-1:0] nb_cnt_i,
  output logic [ELEM_W-1:0]  val_o,
  output logic [COUNT_W-1:0] cnt_o
);

  logic [ELEM_W-1:0]  val_q, val_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic               hit_q;
  logic               occupied, match, del, at_tail, sat;

  assign occupied = USED_W'(idx_i) < ctrl_i.used;
  assign at_tail  = USED_W'(idx_i) == ctrl_i.used;
  assign match    = occupied && (val_q == key_i);
  assign sat      = (cnt_q == {COUNT_W{1'b1}});
  // removing the last occurrence (or a stray zero count) frees the slot
  assign del      = hit_q && ctrl_i.rem && (cnt_q <= COUNT_W'(1));

  assign link_o.shift = link_i.shift | del;
  assign link_o.found = link_i.found | hit_q;
  assign link_o.cnt   = link_i.cnt | (hit_q ? cnt_q : '0);

  assign val_o = val_q;
  assign cnt_o = cnt_q;

  always_comb begin
    val_d = val_q;
    cnt_d = cnt_q;
    if (ctrl_i.update) begin
      if (link_o.shift) begin
        val_d = nb_val_i;
        cnt_d = nb_cnt_i;
      end else if (hit_q && ctrl_i.add && !sat) begin
        cnt_d = cnt_q + COUNT_W'(1);
      end else if (hit_q && ctrl_i.rem && (cnt_q != '0)) begin
        cnt_d = cnt_q - COUNT_W'(1);
      end else if (ctrl_i.append && at_tail) begin
        val_d = key_i;
        cnt_d = COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      hit_q <= match;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/counted_multiset_table_top.sv =====
// Counted multiset table: each request runs a compare cycle, then the count
// update / left-shift compaction cycle through the cell chain, which writes the
// result into the output register; the next request is not taken until that
// update is done. A held output register delays the update, and the next request, until it frees.
// Reset empties the table (entry count and total zero); slot contents are
// not cleared and need no clearing pass. Depends on cmst_pkg, cmst_cell.
`timescale 1ns / 1ps
`default_nettype none

module counted_multiset_table_top import cmst_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  // Controller state
  fsm_e               state_q, state_d;
  logic [CMD_W-1:0]   cmd_q;
  logic [ELEM_W-1:0]  elem_q;
  logic [USED_W-1:0]  used_q, used_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  // Output register
  logic     out_valid_q, out_valid_d;
  out_rsp_t out_rsp_q, out_rsp_d;

  logic accept, upd_en, out_held;

  // Cell chain wiring
  cmst_ctrl_t         ctrl;
  logic [ELEM_W-1:0]  key;
  cmst_link_t         link [CAPACITY+1];
  logic [ELEM_W-1:0]  val_w [CAPACITY+1];
  logic [COUNT_W-1:0] cnt_w [CAPACITY+1];

  // Result of the compare cycle, seen at the end of the chain
  logic               found, full, sat, is_add, is_rem;
  logic [COUNT_W-1:0] cur_cnt;
  logic [COUNT_W-1:0] occ;
  logic [STATUS_W-1:0] status;

  assign out_held   = out_valid_q && out_stall_i;
  assign in_stall_o = (state_q != FSM_IDLE);
  assign accept     = in_valid_i && (state_q == FSM_IDLE);
  // the update only goes ahead once the output register can take the result
  assign upd_en     = (state_q == FSM_UPDATE) && !out_held;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (accept) state_d = FSM_UPDATE;
      end
      FSM_UPDATE: begin
        if (upd_en) state_d = FSM_IDLE;
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      used_q      <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_req_i.command;
      elem_q <= in_req_i.element[ELEM_W-1:0];
    end
    out_rsp_q <= out_rsp_d;
  end

  // Compare runs against the incoming element; the update appends the
  // latched one.
  assign key = (state_q == FSM_IDLE) ? in_req_i.element[ELEM_W-1:0] : elem_q;

  assign is_add  = (cmd_q == CMD_ADD);
  assign is_rem  = (cmd_q == CMD_REMOVE);
  assign found   = link[CAPACITY].found;
  assign cur_cnt = link[CAPACITY].cnt;
  assign full    = (used_q == USED_W'(CAPACITY));
  assign sat     = (cur_cnt == {COUNT_W{1'b1}});

  always_comb begin
    ctrl.capture = accept;
    ctrl.update  = upd_en;
    ctrl.add     = is_add;
    ctrl.rem     = is_rem;
    ctrl.append  = is_add && !found && !full;
    ctrl.used    = used_q;
  end

  // Bookkeeping and result for the request in flight
  always_comb begin
    status  = STAT_OK;
    occ     = '0;
    used_d  = used_q;
    total_d = total_q;
    case (cmd_q)
      CMD_ADD: begin
        if (found) begin
          if (sat) begin
            status = STAT_SATURATED;
            occ    = cur_cnt;
          end else begin
            occ     = cur_cnt + COUNT_W'(1);
            total_d = total_q + TOTAL_W'(1);
          end
        end else if (full) begin
          status = STAT_FULL;
        end else begin
          occ     = COUNT_W'(1);
          used_d  = used_q + USED_W'(1);
          total_d = total_q + TOTAL_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (!found) begin
          status = STAT_NOT_FOUND;
        end else begin
          if (cur_cnt != '0) begin
            occ     = cur_cnt - COUNT_W'(1);
            total_d = total_q - TOTAL_W'(1);
          end
          // last occurrence gone: the chain compacts, one fewer entry
          if (occ == '0) used_d = used_q - USED_W'(1);
        end
      end
      default: begin
        // lookup; the unused command code behaves the same
        occ = cur_cnt;
      end
    endcase
    if (!upd_en) begin
      used_d  = used_q;
      total_d = total_q;
    end
  end

  always_comb begin
    out_valid_d = upd_en || out_held;
    out_rsp_d   = out_rsp_q;
    if (upd_en) begin
      out_rsp_d.status         = status;
      out_rsp_d.present        = found;
      out_rsp_d.occurrences    = OCC_W'(occ);
      out_rsp_d.distinct_count = DISTINCT_W'(used_d);
      out_rsp_d.total_count    = total_d[TOTAL_OUT_W-1:0];
      out_rsp_d.is_empty       = (used_d == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // Chain ends: nothing enters on the left, zeros shift in on the right.
  assign link[0]        = '0;
  assign val_w[CAPACITY] = '0;
  assign cnt_w[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cmst_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (IDX_W'(i)),
      .ctrl_i   (ctrl),
      .key_i    (key),
      .link_i   (link[i]),
      .link_o   (link[i+1]),
      .nb_val_i (val_w[i+1]),
      .nb_cnt_i (cnt_w[i+1]),
      .val_o    (val_w[i]),
      .cnt_o    (cnt_w[i])
    );
  end

endmodule

`default_nettype wire
